// ===== rtl/core/add_with_addressing_modes_macros.svh =====
// Assertion helpers used by add_with_addressing_modes.sv
`ifndef ADD_WITH_ADDRESSING_MODES_MACROS_SVH
`define ADD_WITH_ADDRESSING_MODES_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define AWAM_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("awam check failed");

// Next-cycle implication, disabled while reset is asserted
`define AWAM_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("awam check failed");

`endif

// ===== rtl/core/awam_pkg.sv =====
package awam_pkg;

    // Operand mode codes
    localparam logic [4:0] CODE_IMM = 5'h10;
    localparam logic [4:0] CODE_DIR = 5'h11;
    localparam logic [4:0] CODE_IND = 5'h12;

    // Operations carried in the opcode field
    typedef enum logic [2:0] {
        OP_ADD   = 3'd0,
        OP_WRREG = 3'd1,
        OP_WRMEM = 3'd2,
        OP_RDMEM = 3'd3,
        OP_RDREG = 3'd4
    } op_t;

    // Result status codes
    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_IMMDEST = 2'd1,
        STAT_BAD     = 2'd2
    } status_t;

    // Decoded operand mode
    typedef enum logic [2:0] {
        MODE_REG,
        MODE_IMM,
        MODE_DIR,
        MODE_IND,
        MODE_BAD
    } mode_t;

    // Operations of the shared arithmetic unit
    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    // Register numbers 1..15 name a register
    function automatic logic reg_ok(input logic [15:0] n);
        return (n >= 16'd1) && (n <= 16'd15);
    endfunction

    function automatic mode_t mode_of(input logic [4:0] code);
        mode_t m;
        if (reg_ok({11'd0, code})) begin
            m = MODE_REG;
        end
        else if (code == CODE_IMM) begin
            m = MODE_IMM;
        end
        else if (code == CODE_DIR) begin
            m = MODE_DIR;
        end
        else if (code == CODE_IND) begin
            m = MODE_IND;
        end
        else begin
            m = MODE_BAD;
        end
        return m;
    endfunction

endpackage

// ===== rtl/core/add_with_addressing_modes.sv =====
// Two-operand 16-bit ADD with register, immediate, direct and register-indirect
// operand modes, plus opcodes to write or read one register or one memory word.
// One transfer is taken at a time: s_tready is high only while the block is
// idle, and the result is held on the master side until it is taken. An add
// fetches the source operand, then the destination operand, then writes the sum
// back to the destination. Every memory address is reduced modulo MEM_WORDS:
// by taking its low bits when MEM_WORDS is a power of two, else by
// 17 - clog2(MEM_WORDS) compare-and-subtract steps. All sums and address
// reductions run through one shared adder, and every memory operand costs a
// read through the single port of the data RAM.
// The data memory is not cleared: a read of a word never written is undefined.
`include "add_with_addressing_modes_macros.svh"

module add_with_addressing_modes import awam_pkg::*; #(
    parameter int MEM_WORDS = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // opcode[2:0], dest_code[7:3], source_code[12:8], dest_operand[28:13],
    // source_operand[44:29], zero pad[47:45]
    input  logic [47:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // result_value[15:0], zero_bit[16], status[18:17], zero pad[23:19]
    output logic [23:0] m_tdata
);

    localparam int  AW       = $clog2(MEM_WORDS);
    localparam bit  MEM_POW2 = (MEM_WORDS & (MEM_WORDS - 1)) == 0;
    localparam int  KTOP     = 16 - AW;
    localparam int  KW       = $clog2(KTOP + 2);
    localparam logic [16:0] MEM17 = 17'(MEM_WORDS);

    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_FETCH   = 8'b0000_0010,
        S_REDUCE  = 8'b0000_0100,
        S_MEMRD   = 8'b0000_1000,
        S_MEMWAIT = 8'b0001_0000,
        S_MEMWR   = 8'b0010_0000,
        S_ADD     = 8'b0100_0000,
        S_OUT     = 8'b1000_0000
    } state_t;

    // Input fields
    logic [2:0]  in_opcode;
    logic [4:0]  in_dc;
    logic [4:0]  in_sc;
    logic [15:0] in_dop;
    logic [15:0] in_sop;

    assign in_opcode = s_tdata[2:0];
    assign in_dc     = s_tdata[7:3];
    assign in_sc     = s_tdata[12:8];
    assign in_dop    = s_tdata[28:13];
    assign in_sop    = s_tdata[44:29];

    state_t      state_reg, state_next;
    op_t         op_reg, op_next;
    logic        dphase_reg, dphase_next;
    mode_t       cur_mode_reg, cur_mode_next;
    logic [4:0]  cur_code_reg, cur_code_next;
    logic [15:0] cur_opnd_reg, cur_opnd_next;
    mode_t       dst_mode_reg, dst_mode_next;
    logic [4:0]  dc_reg, dc_next;
    logic [15:0] dop_reg, dop_next;
    logic [15:0] sop_reg, sop_next;
    logic [15:0] src_val_reg, src_val_next;
    logic [15:0] dst_val_reg, dst_val_next;
    logic [15:0] acc_reg, acc_next;
    logic [KW-1:0] step_reg, step_next;
    logic [AW-1:0] addr_reg, addr_next;
    logic [15:0] res_reg, res_next;
    status_t     status_reg, status_next;
    logic        zero_reg, zero_next;

    logic        rf_we;
    logic [3:0]  rf_waddr;
    logic [15:0] rf_wdata;
    logic [3:0]  rf_raddr;
    logic [15:0] rf_rdata;
    logic        ram_we;
    logic [15:0] ram_wdata;
    logic [15:0] ram_rdata;
    alu_op_t     alu_op;
    logic [15:0] alu_a;
    logic [16:0] alu_b;
    logic [15:0] alu_y;
    logic        alu_ge;
    logic [15:0] acc_red;
    logic        fetch_done;
    logic [15:0] fetch_val;
    logic        add_bad;

    awam_regs u_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (rf_we),
        .waddr (rf_waddr),
        .wdata (rf_wdata),
        .raddr (rf_raddr),
        .rdata (rf_rdata)
    );

    awam_ram #(
        .WIDTH (16),
        .DEPTH (MEM_WORDS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (addr_reg),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    awam_alu u_alu (
        .op (alu_op),
        .a  (alu_a),
        .b  (alu_b),
        .y  (alu_y),
        .ge (alu_ge)
    );

    // Shared adder: the sum in the add step, else one reduction step
    always_comb
    begin
        if (state_reg == S_ADD)
        begin
            alu_op = ALU_ADD;
            alu_a  = dst_val_reg;
            alu_b  = {1'b0, src_val_reg};
        end
        else
        begin
            alu_op = ALU_SUB;
            alu_a  = acc_reg;
            alu_b  = MEM17 << step_reg;
        end
    end

    // Keep the difference only where the modulus multiple fits and MEM_WORDS is not a power of two
    assign acc_red = (!MEM_POW2 && alu_ge) ? alu_y : acc_reg;

    // Bad operand codes of an add, visible from the input fields
    always_comb
    begin
        add_bad = 1'b0;
        if ((mode_of(in_sc) == MODE_BAD) ||
            ((mode_of(in_sc) == MODE_IND) && !reg_ok(in_sop)))
        begin
            add_bad = 1'b1;
        end
        if ((mode_of(in_dc) == MODE_BAD) ||
            ((mode_of(in_dc) == MODE_IND) && !reg_ok(in_dop)))
        begin
            add_bad = 1'b1;
        end
    end

    // Sequencer
    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        dphase_next   = dphase_reg;
        cur_mode_next = cur_mode_reg;
        cur_code_next = cur_code_reg;
        cur_opnd_next = cur_opnd_reg;
        dst_mode_next = dst_mode_reg;
        dc_next       = dc_reg;
        dop_next      = dop_reg;
        sop_next      = sop_reg;
        src_val_next  = src_val_reg;
        dst_val_next  = dst_val_reg;
        acc_next      = acc_reg;
        step_next     = step_reg;
        addr_next     = addr_reg;
        res_next      = res_reg;
        status_next   = status_reg;
        zero_next     = zero_reg;
        rf_we         = 1'b0;
        rf_waddr      = dc_reg[3:0] - 4'd1;
        rf_wdata      = alu_y;
        rf_raddr      = cur_code_reg[3:0] - 4'd1;
        ram_we        = 1'b0;
        ram_wdata     = sop_reg;
        fetch_done    = 1'b0;
        fetch_val     = rf_rdata;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next       = op_t'(in_opcode);
                    dc_next       = in_dc;
                    dop_next      = in_dop;
                    sop_next      = in_sop;
                    dst_mode_next = mode_of(in_dc);
                    status_next   = STAT_OK;
                    res_next      = 16'd0;
                    state_next    = S_OUT;
                    unique case (op_t'(in_opcode))
                        OP_ADD:
                        begin
                            if (in_dc == CODE_IMM)
                            begin
                                status_next = STAT_IMMDEST;
                            end
                            else if (add_bad)
                            begin
                                status_next = STAT_BAD;
                            end
                            else
                            begin
                                dphase_next   = 1'b0;
                                cur_mode_next = mode_of(in_sc);
                                cur_code_next = in_sc;
                                cur_opnd_next = in_sop;
                                state_next    = S_FETCH;
                            end
                        end
                        OP_WRREG:
                        begin
                            if (reg_ok({11'd0, in_dc}))
                            begin
                                rf_we    = 1'b1;
                                rf_waddr = in_dc[3:0] - 4'd1;
                                rf_wdata = in_sop;
                                res_next = in_sop;
                            end
                            else
                            begin
                                status_next = STAT_BAD;
                            end
                        end
                        OP_WRMEM, OP_RDMEM:
                        begin
                            acc_next   = in_dop;
                            step_next  = KW'(KTOP);
                            state_next = S_REDUCE;
                        end
                        OP_RDREG:
                        begin
                            if (reg_ok({11'd0, in_dc}))
                            begin
                                rf_raddr = in_dc[3:0] - 4'd1;
                                res_next = rf_rdata;
                            end
                            else
                            begin
                                status_next = STAT_BAD;
                            end
                        end
                        default:
                        begin
                            status_next = STAT_BAD;
                        end
                    endcase
                end
            end
            S_FETCH:
            begin
                if (cur_mode_reg != MODE_REG)
                begin
                    rf_raddr = cur_opnd_reg[3:0] - 4'd1;
                end
                unique case (cur_mode_reg)
                    MODE_REG:
                    begin
                        fetch_done = 1'b1;
                        fetch_val  = rf_rdata;
                    end
                    MODE_IMM:
                    begin
                        fetch_done = 1'b1;
                        fetch_val  = cur_opnd_reg;
                    end
                    MODE_DIR:
                    begin
                        acc_next   = cur_opnd_reg;
                        step_next  = KW'(KTOP);
                        state_next = S_REDUCE;
                    end
                    MODE_IND:
                    begin
                        acc_next   = rf_rdata;
                        step_next  = KW'(KTOP);
                        state_next = S_REDUCE;
                    end
                    default:
                    begin
                        status_next = STAT_BAD;
                        res_next    = 16'd0;
                        state_next  = S_OUT;
                    end
                endcase
            end
            S_REDUCE:
            begin
                acc_next = acc_red;
                if (MEM_POW2 || (step_reg == '0))
                begin
                    addr_next  = acc_red[AW-1:0];
                    state_next = (op_reg == OP_WRMEM) ? S_MEMWR : S_MEMRD;
                end
                else
                begin
                    step_next = step_reg - KW'(1);
                end
            end
            S_MEMRD:
            begin
                state_next = S_MEMWAIT;
            end
            S_MEMWAIT:
            begin
                if (op_reg == OP_RDMEM)
                begin
                    res_next   = ram_rdata;
                    state_next = S_OUT;
                end
                else
                begin
                    fetch_done = 1'b1;
                    fetch_val  = ram_rdata;
                end
            end
            S_MEMWR:
            begin
                ram_we     = 1'b1;
                ram_wdata  = sop_reg;
                res_next   = sop_reg;
                state_next = S_OUT;
            end
            S_ADD:
            begin
                if (dst_mode_reg == MODE_REG)
                begin
                    rf_we    = 1'b1;
                    rf_waddr = dc_reg[3:0] - 4'd1;
                    rf_wdata = alu_y;
                end
                else
                begin
                    ram_we    = 1'b1;
                    ram_wdata = alu_y;
                end
                zero_next  = (alu_y == 16'd0);
                res_next   = alu_y;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (m_tready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Operand in hand: move from source to destination, then to the add
        if (fetch_done)
        begin
            if (!dphase_reg)
            begin
                src_val_next  = fetch_val;
                dphase_next   = 1'b1;
                cur_mode_next = dst_mode_reg;
                cur_code_next = dc_reg;
                cur_opnd_next = dop_reg;
                state_next    = S_FETCH;
            end
            else
            begin
                dst_val_next = fetch_val;
                state_next   = S_ADD;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            dphase_reg <= 1'b0;
            step_reg   <= '0;
            zero_reg   <= 1'b0;
            status_reg <= STAT_OK;
        end
        else
        begin
            state_reg  <= state_next;
            dphase_reg <= dphase_next;
            step_reg   <= step_next;
            zero_reg   <= zero_next;
            status_reg <= status_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        cur_mode_reg <= cur_mode_next;
        cur_code_reg <= cur_code_next;
        cur_opnd_reg <= cur_opnd_next;
        dst_mode_reg <= dst_mode_next;
        dc_reg       <= dc_next;
        dop_reg      <= dop_next;
        sop_reg      <= sop_next;
        src_val_reg  <= src_val_next;
        dst_val_reg  <= dst_val_next;
        acc_reg      <= acc_next;
        addr_reg     <= addr_next;
        res_reg      <= res_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tdata  = {5'd0, status_reg, zero_reg, res_reg};

    // Checks
    `AWAM_ASSERT_NOW(a_sides_apart, clk, rst_n, m_tvalid, !s_tready)
    `AWAM_ASSERT_NOW(a_reject_zero, clk, rst_n,
        m_tvalid && (status_reg != STAT_OK), res_reg == 16'd0)
    `AWAM_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, s_tvalid && s_tready, !s_tready)
    `AWAM_ASSERT_NEXT(a_zero_only_by_add, clk, rst_n,
        state_reg != S_ADD, zero_reg == $past(zero_reg))

endmodule

// ===== rtl/core/awam_ram.sv =====
module awam_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Single port, read before write, registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/awam_regs.sv =====
module awam_regs import awam_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        we,
    input  logic [3:0]  waddr,
    input  logic [15:0] wdata,
    input  logic [3:0]  raddr,
    output logic [15:0] rdata
);

    localparam int NREGS = 15;

    logic [15:0] rf_reg [NREGS];

    // Write one register; reset clears the file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NREGS; i++)
            begin
                rf_reg[i] <= '0;
            end
        end
        else if (we && (waddr < 4'(NREGS)))
        begin
            rf_reg[waddr] <= wdata;
        end
    end

    // One read port; the unused index reads as zero
    assign rdata = (raddr < 4'(NREGS)) ? rf_reg[raddr] : 16'd0;

endmodule

// ===== rtl/core/awam_alu.sv =====
module awam_alu import awam_pkg::*; (
    input  alu_op_t     op,
    input  logic [15:0] a,
    input  logic [16:0] b,
    output logic [15:0] y,
    output logic        ge
);

    logic [17:0] sum;

    // One adder: plain add, or subtract through inverted operand and carry in
    always_comb
    begin
        unique case (op)
            ALU_ADD: sum = {2'b00, a} + {2'b00, b[15:0]};
            ALU_SUB: sum = {2'b00, a} + ~{1'b0, b} + 18'd1;
            default: sum = '0;
        endcase
    end

    assign y  = sum[15:0];
    // No borrow out means a >= b
    assign ge = ~sum[17];

endmodule
